@@ hdl/anbx_pkg.sv @@
// Shared constants, types and helpers for the Annex B NAL unit splitter.
package anbx_pkg;

    // Capacity of the unit table and width of the stream position counters.
    localparam int MAX_UNITS = 4096;
    localparam int POS_W     = 32;

    // Unit counter holds 0 .. MAX_UNITS.
    localparam int CNT_W = $clog2(MAX_UNITS) + 1;

    // Fixed widths of the result fields.
    localparam int IDX_W = 12;
    localparam int OUT_POS_W = 32;

    // Depth of the queue between the scanner and the result stage (power of two).
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input opcodes.
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Byte values and unit types of interest.
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] TYPE_MASK = 8'h1f;
    localparam logic [4:0] TYPE_SLICE = 5'h01;
    localparam logic [4:0] TYPE_IDR   = 5'h05;
    localparam logic [4:0] TYPE_SPS   = 5'h07;
    localparam logic [4:0] TYPE_PPS   = 5'h08;

    // Start code history after reset or after a start code: no zeros seen.
    localparam logic [23:0] HISTORY_IDLE = 24'hffffff;

    typedef logic [POS_W-1:0] pos_t;

    // One closed unit, as found by the scanner.
    typedef struct packed {
        logic [7:0] header;
        pos_t       offset;
        pos_t       size;
    } unit_rec_t;

    // Status of the queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Widen or narrow a position value to the fixed result width.
    function automatic logic [OUT_POS_W-1:0] to_out_pos(input pos_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_POS_W-1:0];
    endfunction

    // Unit counter to the fixed index width (low bits kept).
    function automatic logic [IDX_W-1:0] to_index(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[IDX_W-1:0];
    endfunction

endpackage

@@ hdl/anbx_front.sv @@
// Byte scanner: finds start codes and tracks the open unit's offset, size and header.
module anbx_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                opcode,
    input  logic [7:0]          data_byte,
    output logic                push,
    output anbx_pkg::unit_rec_t rec
);

    logic [23:0]    hist_reg, hist_next;
    logic           inside_reg, inside_next;
    anbx_pkg::pos_t pos_reg, pos_next;
    anbx_pkg::pos_t start_reg, start_next;
    anbx_pkg::pos_t bytes_reg, bytes_next;
    logic [7:0]     cap_reg, cap_next;

    anbx_pkg::pos_t pos_inc;
    anbx_pkg::pos_t bytes_less_code;
    anbx_pkg::pos_t close_size;
    logic           start_code;

    assign pos_inc         = pos_reg + anbx_pkg::pos_t'(1);
    assign bytes_less_code = bytes_reg - anbx_pkg::pos_t'(3);
    assign start_code      = (hist_reg == 24'h000000) && (data_byte == anbx_pkg::BYTE_ONE);

    // The three zeros of a start code were counted into the unit they close.
    assign close_size = (opcode == anbx_pkg::OP_END) ? bytes_reg : bytes_less_code;

    // Record of the unit being closed by this transaction.
    always_comb begin
        rec.size   = close_size;
        rec.offset = start_reg;
        rec.header = (close_size == '0) ? anbx_pkg::BYTE_ZERO : cap_reg;
        push       = accept && inside_reg && ((opcode == anbx_pkg::OP_END) || start_code);
    end

    // Scanner state update.
    always_comb begin
        hist_next   = hist_reg;
        inside_next = inside_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        bytes_next  = bytes_reg;
        cap_next    = cap_reg;
        if (accept) begin
            if (opcode == anbx_pkg::OP_END) begin
                // End of stream: the next bytes form a new stream.
                hist_next   = anbx_pkg::HISTORY_IDLE;
                inside_next = 1'b0;
                pos_next    = '0;
                start_next  = '0;
                bytes_next  = '0;
                cap_next    = anbx_pkg::BYTE_ZERO;
            end else begin
                pos_next = pos_inc;
                if (start_code) begin
                    inside_next = 1'b1;
                    start_next  = pos_inc;
                    bytes_next  = '0;
                    cap_next    = anbx_pkg::BYTE_ZERO;
                    hist_next   = anbx_pkg::HISTORY_IDLE;
                end else begin
                    hist_next = {hist_reg[15:0], data_byte};
                    if (inside_reg) begin
                        if (bytes_reg == '0) begin
                            cap_next = data_byte;
                        end
                        // Size saturates at the largest position value.
                        if (bytes_reg != '1) begin
                            bytes_next = bytes_reg + anbx_pkg::pos_t'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg   <= anbx_pkg::HISTORY_IDLE;
            inside_reg <= 1'b0;
            pos_reg    <= '0;
            start_reg  <= '0;
            bytes_reg  <= '0;
            cap_reg    <= anbx_pkg::BYTE_ZERO;
        end else begin
            hist_reg   <= hist_next;
            inside_reg <= inside_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            bytes_reg  <= bytes_next;
            cap_reg    <= cap_next;
        end
    end

endmodule

@@ hdl/anbx_queue.sv @@
// Short queue of closed unit records between the scanner and the result stage.
module anbx_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  anbx_pkg::unit_rec_t  wr_rec,
    input  logic                 pop,
    output anbx_pkg::unit_rec_t  rd_rec,
    output anbx_pkg::q_status_t  status
);

    anbx_pkg::unit_rec_t             mem_reg [anbx_pkg::Q_DEPTH];
    logic [anbx_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [anbx_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [anbx_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == anbx_pkg::Q_CNT_W'(anbx_pkg::Q_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign rd_rec       = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + anbx_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + anbx_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + anbx_pkg::Q_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - anbx_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Record storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

@@ hdl/anbx_back.sv @@
// Result stage: numbers units, marks first SPS/PPS and slices, holds the output register.
module anbx_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  anbx_pkg::unit_rec_t           rd_rec,
    input  anbx_pkg::q_status_t           q_status,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_header_byte,
    output logic [4:0]                    m_unit_type,
    output logic [anbx_pkg::OUT_POS_W-1:0] m_unit_offset,
    output logic [anbx_pkg::OUT_POS_W-1:0] m_unit_size,
    output logic [anbx_pkg::IDX_W-1:0]    m_unit_index,
    output logic                          m_first_sps,
    output logic                          m_first_pps,
    output logic                          m_video_slice,
    output logic                          m_table_full
);

    localparam logic [anbx_pkg::CNT_W-1:0] CNT_CAP  = anbx_pkg::CNT_W'(anbx_pkg::MAX_UNITS);
    localparam logic [anbx_pkg::CNT_W-1:0] CNT_LAST = anbx_pkg::CNT_W'(anbx_pkg::MAX_UNITS - 1);

    logic [anbx_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       sps_seen_reg, sps_seen_next;
    logic                       pps_seen_reg, pps_seen_next;
    logic                       valid_reg, valid_next;

    logic [7:0]                 hdr_reg;
    logic [4:0]                 type_reg;
    logic [anbx_pkg::OUT_POS_W-1:0] offset_reg, size_reg;
    logic [anbx_pkg::IDX_W-1:0] index_reg;
    logic                       first_sps_reg, first_pps_reg, slice_reg, full_reg;

    logic [7:0]                 hdr_masked;
    logic [4:0]                 cur_type;
    logic                       cur_full;

    assign pop        = !q_status.empty && (!valid_reg || m_ready);
    assign hdr_masked = rd_rec.header & anbx_pkg::TYPE_MASK;
    assign cur_type   = hdr_masked[4:0];
    assign cur_full   = (cnt_reg >= CNT_CAP);

    // Unit numbering, first-seen flags and output valid.
    always_comb begin
        cnt_next      = cnt_reg;
        sps_seen_next = sps_seen_reg;
        pps_seen_next = pps_seen_reg;
        valid_next    = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (pop) begin
            valid_next = 1'b1;
            if (!cur_full) begin
                cnt_next = cnt_reg + anbx_pkg::CNT_W'(1);
            end
            if (cur_type == anbx_pkg::TYPE_SPS) begin
                sps_seen_next = 1'b1;
            end
            if (cur_type == anbx_pkg::TYPE_PPS) begin
                pps_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            sps_seen_reg <= 1'b0;
            pps_seen_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            sps_seen_reg <= sps_seen_next;
            pps_seen_reg <= pps_seen_next;
            valid_reg    <= valid_next;
        end
    end

    // Output payload, loaded when a record leaves the queue.
    always_ff @(posedge aclk) begin
        if (pop) begin
            hdr_reg       <= rd_rec.header;
            type_reg      <= cur_type;
            offset_reg    <= anbx_pkg::to_out_pos(rd_rec.offset);
            size_reg      <= anbx_pkg::to_out_pos(rd_rec.size);
            index_reg     <= anbx_pkg::to_index(cur_full ? CNT_LAST : cnt_reg);
            first_sps_reg <= (cur_type == anbx_pkg::TYPE_SPS) && !sps_seen_reg;
            first_pps_reg <= (cur_type == anbx_pkg::TYPE_PPS) && !pps_seen_reg;
            slice_reg     <= (cur_type == anbx_pkg::TYPE_SLICE) ||
                             (cur_type == anbx_pkg::TYPE_IDR);
            full_reg      <= cur_full;
        end
    end

    assign m_valid       = valid_reg;
    assign m_header_byte = hdr_reg;
    assign m_unit_type   = type_reg;
    assign m_unit_offset = offset_reg;
    assign m_unit_size   = size_reg;
    assign m_unit_index  = index_reg;
    assign m_first_sps   = first_sps_reg;
    assign m_first_pps   = first_pps_reg;
    assign m_video_slice = slice_reg;
    assign m_table_full  = full_reg;

endmodule

@@ hdl/annexb_nal_unit_splitter.sv @@
// Top level of the Annex B NAL unit splitter: scanner, record queue and result stage.
// Throughput: one byte or end item accepted per cycle unless the record queue is full.
// After the transaction that closes its unit, a result passes through the record queue
// and then the output register.
// The input stalls only while the four-entry record queue is full.
// Reset (aresetn, synchronous, active low) clears scanner, queue, counters and flags.
module annexb_nal_unit_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_header_byte,
    output logic [4:0]  m_unit_type,
    output logic [31:0] m_unit_offset,
    output logic [31:0] m_unit_size,
    output logic [11:0] m_unit_index,
    output logic        m_first_sps,
    output logic        m_first_pps,
    output logic        m_video_slice,
    output logic        m_table_full
);

    logic                 accept;
    logic                 q_push;
    logic                 q_pop;
    anbx_pkg::unit_rec_t  wr_rec;
    anbx_pkg::unit_rec_t  rd_rec;
    anbx_pkg::q_status_t  q_status;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    anbx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .opcode    (s_opcode),
        .data_byte (s_data_byte),
        .push      (q_push),
        .rec       (wr_rec)
    );

    anbx_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_rec  (wr_rec),
        .pop     (q_pop),
        .rd_rec  (rd_rec),
        .status  (q_status)
    );

    anbx_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_rec        (rd_rec),
        .q_status      (q_status),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_header_byte (m_header_byte),
        .m_unit_type   (m_unit_type),
        .m_unit_offset (m_unit_offset),
        .m_unit_size   (m_unit_size),
        .m_unit_index  (m_unit_index),
        .m_first_sps   (m_first_sps),
        .m_first_pps   (m_first_pps),
        .m_video_slice (m_video_slice),
        .m_table_full  (m_table_full)
    );

    // A record is never written into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("record pushed into a full queue");

    // With nothing queued and nothing shown, no result can appear in the next cycle.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.empty && !m_valid) |=> !m_valid)
        else $error("result appeared without a queued record");

    // A unit past the table capacity carries the last index.
    a_full_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |->
            (m_unit_index == anbx_pkg::to_index(anbx_pkg::CNT_W'(anbx_pkg::MAX_UNITS - 1))))
        else $error("full table but index is not the last entry");

    // The first-SPS and first-PPS marks agree with the unit type.
    a_first_type: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_first_sps || m_first_pps)) |->
            ((m_first_sps && m_unit_type == anbx_pkg::TYPE_SPS) ||
             (m_first_pps && m_unit_type == anbx_pkg::TYPE_PPS)))
        else $error("first SPS or PPS mark on a unit of another type");

endmodule
